[rtl/qsrs_pkg.sv]
// Shared types, constants and the sort-key function for the quicksort record sorter.
// No dependencies; imported by quicksort_record_sorter_core.
package qsrs_pkg;

	localparam int MAX_RECORDS_DEF = 64;

	typedef struct packed {
		logic [15:0]        id;
		logic signed [31:0] price;
		logic [15:0]        dur;
	} record_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_POP,
		ST_RANGE,
		ST_PIVOT,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_FIN,
		ST_FIN_A,
		ST_FIN_B,
		ST_PUSH_R,
		ST_PUSH_L,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	// Unsigned key that orders like the signed price or the plain duration.
	function automatic logic [31:0] key_of(input record_t rec, input logic by_price);
		logic [31:0] k;
		if (by_price) begin
			k = {~rec.price[31], rec.price[30:0]};
		end else begin
			k = {16'h0000, rec.dur};
		end
		return k;
	endfunction

endpackage

[rtl/quicksort_record_sorter_core.sv]
// Quicksort record sorter: record store, range stack and the sequencer that sorts them.
// Depends on qsrs_pkg (record_t, state_t, key_of, MAX_RECORDS_DEF).

// Records load at one word per cycle until one flagged last_record arrives; input is then
// stalled while the set is sorted in place (Lomuto quicksort, pivot at the top of each
// range, left part first) and the sorted words are emitted in order. All record moves go
// through one synchronous single-write memory, so a swap reads the slot entry, then writes
// both entries in turn (ST_SWAP_A, ST_SWAP_B); each word is emitted by a read (ST_EMIT_RD)
// and a load into the output register (ST_EMIT_WR) that waits while the output is stalled.
// Records beyond MAX_RECORDS are dropped and every word of that set carries dropped_flag.
// sort_by_price is sampled when the last record is accepted.
module quicksort_record_sorter_core
	import qsrs_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        record_id,
	input  logic signed [31:0] price_cents,
	input  logic [15:0]        duration_minutes,
	input  logic               last_record,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        out_record_id,
	output logic signed [31:0] out_price_cents,
	output logic [15:0]        out_duration_minutes,
	output logic               out_last,
	output logic               dropped_flag
);

	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	state_t state_q, state_d;

	logic                 sort_by_price_q;
	logic                 by_price_q;
	logic [CNT_W-1:0]     count_q;
	logic                 overflow_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     top_q;
	logic [IDX_W-1:0]     lo_q, hi_q, j_q, slot_q, k_q;
	logic [31:0]          pk_q;
	record_t              pivot_q, tmp_q;

	// memories
	record_t              rec_mem [MAX_RECORDS];
	record_t              rec_rdata_q;
	logic [2*IDX_W-1:0]   stk_mem [MAX_RECORDS];
	logic [2*IDX_W-1:0]   stk_rdata_q;

	logic                 rec_we, rec_re;
	logic [IDX_W-1:0]     rec_waddr, rec_raddr;
	record_t              rec_wdata;
	logic                 stk_we, stk_re;
	logic [IDX_W-1:0]     stk_waddr, stk_raddr;
	logic [2*IDX_W-1:0]   stk_wdata;

	logic                 out_valid_q;
	record_t              out_rec_q;
	logic                 out_last_q, dropped_q;

	logic                 ld_accept, has_room, out_free;
	logic [CNT_W-1:0]     n_next;
	logic                 multi;
	logic                 less, slot_is_j, at_end, emit_last, push_r, push_l;
	logic [IDX_W-1:0]     j_next;
	logic [IDX_W-1:0]     stk_lo, stk_hi;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_LOAD);
	assign ld_accept = in_valid && !in_stall;
	assign has_room  = (count_q < CNT_W'(MAX_RECORDS));
	assign n_next    = has_room ? (count_q + CNT_W'(1)) : count_q;
	assign multi     = (n_next > CNT_W'(1));
	assign out_free  = !out_valid_q || !out_stall;

	assign stk_lo    = stk_rdata_q[2*IDX_W-1:IDX_W];
	assign stk_hi    = stk_rdata_q[IDX_W-1:0];
	assign less      = (key_of(rec_rdata_q, by_price_q) < pk_q);
	assign slot_is_j = (slot_q == j_q);
	assign j_next    = j_q + IDX_W'(1);
	assign at_end    = (j_next == hi_q);
	assign emit_last = ((CNT_W'(k_q) + CNT_W'(1)) == n_q);
	assign push_r    = (({1'b0, slot_q} + (IDX_W+1)'(1)) < {1'b0, hi_q});
	assign push_l    = (({1'b0, lo_q} + (IDX_W+1)'(1)) < {1'b0, slot_q});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (ld_accept && last_record) begin
					state_d = multi ? ST_POP : ST_EMIT_RD;
				end
			end
			ST_POP:    state_d = (top_q == '0) ? ST_EMIT_RD : ST_RANGE;
			ST_RANGE:  state_d = ST_PIVOT;
			ST_PIVOT:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (less && !slot_is_j) begin
					state_d = ST_SWAP_A;
				end else if (at_end) begin
					state_d = ST_FIN;
				end
			end
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: state_d = at_end ? ST_FIN : ST_SCAN;
			ST_FIN:    state_d = (slot_q != hi_q) ? ST_FIN_A : ST_PUSH_R;
			ST_FIN_A:  state_d = ST_FIN_B;
			ST_FIN_B:  state_d = ST_PUSH_R;
			ST_PUSH_R: state_d = ST_PUSH_L;
			ST_PUSH_L: state_d = ST_POP;
			ST_EMIT_RD: state_d = ST_EMIT_WR;
			ST_EMIT_WR: begin
				if (out_free) begin
					state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	// memory port control
	always_comb begin
		rec_we    = 1'b0;
		rec_waddr = '0;
		rec_wdata = tmp_q;
		rec_re    = 1'b0;
		rec_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (ld_accept && has_room) begin
					rec_we    = 1'b1;
					rec_waddr = count_q[IDX_W-1:0];
					rec_wdata = '{id: record_id, price: price_cents, dur: duration_minutes};
				end
				if (ld_accept && last_record && multi) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = {IDX_W'(0), IDX_W'(n_next - CNT_W'(1))};
				end
			end
			ST_POP: begin
				if (top_q != '0) begin
					stk_re    = 1'b1;
					stk_raddr = IDX_W'(top_q - CNT_W'(1));
				end
			end
			ST_RANGE: begin
				rec_re    = 1'b1;
				rec_raddr = stk_hi;
			end
			ST_PIVOT: begin
				rec_re    = 1'b1;
				rec_raddr = j_q;
			end
			ST_SCAN: begin
				if (less && !slot_is_j) begin
					rec_re    = 1'b1;
					rec_raddr = slot_q;
				end else if (!at_end) begin
					rec_re    = 1'b1;
					rec_raddr = j_next;
				end
			end
			ST_SWAP_A: begin
				rec_we    = 1'b1;
				rec_waddr = slot_q;
				rec_wdata = tmp_q;
			end
			ST_SWAP_B: begin
				rec_we    = 1'b1;
				rec_waddr = j_q;
				rec_wdata = tmp_q;
				if (!at_end) begin
					rec_re    = 1'b1;
					rec_raddr = j_next;
				end
			end
			ST_FIN: begin
				if (slot_q != hi_q) begin
					rec_re    = 1'b1;
					rec_raddr = slot_q;
				end
			end
			ST_FIN_A: begin
				rec_we    = 1'b1;
				rec_waddr = slot_q;
				rec_wdata = pivot_q;
			end
			ST_FIN_B: begin
				rec_we    = 1'b1;
				rec_waddr = hi_q;
				rec_wdata = tmp_q;
			end
			ST_PUSH_R: begin
				if (push_r) begin
					stk_we    = 1'b1;
					stk_waddr = top_q[IDX_W-1:0];
					stk_wdata = {slot_q + IDX_W'(1), hi_q};
				end
			end
			ST_PUSH_L: begin
				if (push_l) begin
					stk_we    = 1'b1;
					stk_waddr = top_q[IDX_W-1:0];
					stk_wdata = {lo_q, slot_q - IDX_W'(1)};
				end
			end
			ST_EMIT_RD: begin
				rec_re    = 1'b1;
				rec_raddr = k_q;
			end
			ST_EMIT_WR: ;
			default: ;
		endcase
	end

	// record store and range stack, read data registered
	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (rec_re) begin
			rec_rdata_q <= rec_mem[rec_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[stk_raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			sort_by_price_q <= 1'b1;
			by_price_q      <= 1'b1;
			count_q         <= '0;
			overflow_q      <= 1'b0;
			n_q             <= '0;
			top_q           <= '0;
			k_q             <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				sort_by_price_q <= cfg_data;
			end
			if (state_q == ST_LOAD && ld_accept) begin
				if (has_room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
				if (last_record) begin
					by_price_q <= sort_by_price_q;
					n_q        <= n_next;
					k_q        <= '0;
					top_q      <= multi ? CNT_W'(1) : '0;
				end
			end
			if (state_q == ST_POP && top_q != '0) begin
				top_q <= top_q - CNT_W'(1);
			end
			if ((state_q == ST_PUSH_R && push_r) || (state_q == ST_PUSH_L && push_l)) begin
				top_q <= top_q + CNT_W'(1);
			end
			if (state_q == ST_EMIT_WR && out_free) begin
				k_q <= k_q + IDX_W'(1);
				if (emit_last) begin
					count_q    <= '0;
					overflow_q <= 1'b0;
				end
			end
			// hold the word until taken, then drop valid unless a new one loads
			if (state_q == ST_EMIT_WR && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// partition datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RANGE: begin
				lo_q   <= stk_lo;
				hi_q   <= stk_hi;
				j_q    <= stk_lo;
				slot_q <= stk_lo;
			end
			ST_PIVOT: begin
				pivot_q <= rec_rdata_q;
				pk_q    <= key_of(rec_rdata_q, by_price_q);
			end
			ST_SCAN: begin
				if (less && !slot_is_j) begin
					tmp_q <= rec_rdata_q;
				end else begin
					j_q <= j_next;
					if (less) begin
						slot_q <= slot_q + IDX_W'(1);
					end
				end
			end
			ST_SWAP_A: tmp_q <= rec_rdata_q;
			ST_SWAP_B: begin
				j_q    <= j_next;
				slot_q <= slot_q + IDX_W'(1);
			end
			ST_FIN_A:  tmp_q <= rec_rdata_q;
			default: ;
		endcase
	end

	// output word
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_WR && out_free) begin
			out_rec_q  <= rec_rdata_q;
			out_last_q <= emit_last;
			dropped_q  <= overflow_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign out_record_id        = out_rec_q.id;
	assign out_price_cents      = out_rec_q.price;
	assign out_duration_minutes = out_rec_q.dur;
	assign out_last             = out_last_q;
	assign dropped_flag         = dropped_q;

	// the sequencer never reads an entry in the cycle it writes it
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we && rec_re |-> rec_waddr != rec_raddr)
		else $error("record store read and write hit the same entry");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CNT_W'(MAX_RECORDS / 2))
		else $error("range stack deeper than the record count allows");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SWAP_A || state_q == ST_SWAP_B)
			|-> (j_q < hi_q && slot_q <= j_q && lo_q <= slot_q))
		else $error("partition indices out of order");

	a_emit_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_WR && out_free |=> out_valid_q)
		else $error("emitted word not presented");

endmodule
